>>> rtl/tsts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDMA slot keeper package
// Shared item types, register indexes, algorithm codes and unit opcodes.
// ----------------------------------------------------------------------------
package tsts_pkg;

  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int MASK_W      = 64;
  localparam int TICKS_OUT_W = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ALG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT  = 2'd3;

  localparam logic [1:0] ALG_GAP   = 2'd1;
  localparam logic [1:0] ALG_EPOCH = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 7'd64;
  localparam logic [31:0]      INIT_TICKS     = 32'd1000;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] rx_slot;
  } in_item_t;

  typedef struct packed {
    logic                   send_enable;
    logic [SLOT_W-1:0]      slot_index;
    logic [TICKS_OUT_W-1:0] slot_ticks;
    logic [TICKS_OUT_W-1:0] epoch_ticks;
  } out_item_t;

endpackage

>>> rtl/tsts_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDMA slot keeper stream interface
// Valid/ready channel that carries one item of type ItemT.
// ----------------------------------------------------------------------------
interface tsts_stream_if #(
  parameter type ItemT = logic
);
  logic valid;
  logic ready;
  ItemT payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tsts_divmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDMA slot keeper arithmetic unit
// Bit-serial restoring divider and shift-add multiplier with saturation.
// ----------------------------------------------------------------------------
module tsts_divmul #(
  parameter int TICK_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsts_pkg::unit_req_t           req_i,
  input  logic [TICK_WIDTH-1:0]         a_i,
  input  logic [tsts_pkg::CNT_W-1:0]    b_i,
  output logic                          done_o,
  output logic [TICK_WIDTH-1:0]         quo_o,
  output logic [tsts_pkg::CNT_W-1:0]    rem_o,
  output logic [TICK_WIDTH-1:0]         prod_o
);

  localparam int CW    = tsts_pkg::CNT_W;
  localparam int StepW = $clog2(TICK_WIDTH + 1);
  localparam int AccW  = TICK_WIDTH + CW;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  tsts_pkg::unit_op_e   op_q, op_d;
  logic [StepW-1:0]     cnt_q, cnt_d;
  logic [TICK_WIDTH-1:0] a_q, a_d;
  logic [CW-1:0]        b_q, b_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [CW:0]          part;
  logic [CW+1:0]        diff;

  assign part = {rem_q, a_q[TICK_WIDTH-1]};
  assign diff = {1'b0, part} - {2'b00, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = a_i;
      b_d    = b_i;
      rem_d  = '0;
      acc_d  = '0;
      cnt_d  = (req_i.op == tsts_pkg::OP_DIV) ? StepW'(TICK_WIDTH) : StepW'(CW);
    end else if (busy_q) begin
      if (op_q == tsts_pkg::OP_DIV) begin
        if (!diff[CW+1]) begin
          rem_d = diff[CW-1:0];
          a_d   = {a_q[TICK_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = part[CW-1:0];
          a_d   = {a_q[TICK_WIDTH-2:0], 1'b0};
        end
      end else begin
        acc_d = {acc_q[AccW-2:0], 1'b0} + (b_q[CW-1] ? AccW'(a_q) : '0);
        b_d   = {b_q[CW-2:0], 1'b0};
      end
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= tsts_pkg::OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quo_o  = a_q;
  assign rem_o  = rem_q;
  assign prod_o = (acc_q > AccW'({TICK_WIDTH{1'b1}})) ? {TICK_WIDTH{1'b1}}
                                                       : acc_q[TICK_WIDTH-1:0];

endmodule

>>> rtl/tdma_slot_timecode_sync_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDMA slot keeper with time-code synchronization
// Tracks the current slot and slot length, re-estimates timing from time codes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  in_i     in   valid/ready   mode, rx_slot
//  out_o    out  valid/ready   send_enable, slot_index, slot_ticks, epoch_ticks
//  cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// Most items complete directly in the idle state.
// An item that needs a slot modulo or an epoch division runs in the shared
// bit-serial unit; a rescale in slot 0 adds a serial multiply after the
// division. Reset leaves the block ready at once.
// One finished item may wait in the output register while one more is taken.
module tdma_slot_timecode_sync_core #(
  parameter int MAX_SLOTS  = 64,
  parameter int TICK_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tsts_stream_if.sink                         in_i,
  tsts_stream_if.source                       out_o,
  input  logic                                cfg_we_i,
  input  logic [tsts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsts_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW = tsts_pkg::SLOT_W;
  localparam int CW = tsts_pkg::CNT_W;
  localparam int OW = tsts_pkg::TICKS_OUT_W;
  localparam int WW = (TICK_WIDTH > OW) ? TICK_WIDTH : OW;
  localparam logic [WW-1:0] TickMaxW = WW'({TICK_WIDTH{1'b1}});
  localparam logic [WW-1:0] InitW    = WW'(tsts_pkg::INIT_TICKS);
  localparam logic [TICK_WIDTH-1:0] SpReset =
    (InitW > TickMaxW) ? {TICK_WIDTH{1'b1}} : InitW[TICK_WIDTH-1:0];

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOT = 3'd1;
  localparam logic [2:0] S_QSP  = 3'd2;
  localparam logic [2:0] S_ADDQ = 3'd3;
  localparam logic [2:0] S_MULP = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [1:0]                alg_q;
  logic [CW-1:0]             slot_count_q;
  logic [tsts_pkg::MASK_W-1:0] mask_q;
  logic [SW-1:0]             cs_q, cs_d;
  logic [TICK_WIDTH-1:0]     se_q, se_d;
  logic [TICK_WIDTH-1:0]     ee_q, ee_d;
  logic [TICK_WIDTH-1:0]     sp_q, sp_d;
  logic [TICK_WIDTH-1:0]     ep_q, ep_d;
  logic                      synced_q, synced_d;
  logic                      te_q, te_d;
  logic                      pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  tsts_pkg::out_item_t       out_q, out_d;

  tsts_pkg::unit_req_t       ureq;
  logic [TICK_WIDTH-1:0]     ua;
  logic                      u_done;
  logic [TICK_WIDTH-1:0]     u_quo;
  logic [CW-1:0]             u_rem;
  logic [TICK_WIDTH-1:0]     u_prod;

  logic [CW-1:0]             n_eff;
  logic                      in_acc;
  logic                      fin;
  logic                      out_free;
  logic [TICK_WIDTH-1:0]     se_inc, ee_inc;
  logic [CW-1:0]             nxt7;
  logic [SW-1:0]             nxt6;
  logic [CW-1:0]             code7;
  logic [TICK_WIDTH:0]       sum_gap, sum_quo;
  logic [TICK_WIDTH-1:0]     sp_gap, sp_quo;

  function automatic logic [OW-1:0] to_out(input logic [TICK_WIDTH-1:0] v);
    logic [WW-1:0] e;
    e = WW'(v);
    to_out = (e > WW'({OW{1'b1}})) ? {OW{1'b1}} : e[OW-1:0];
  endfunction

  function automatic logic [TICK_WIDTH-1:0] ld_init(input logic [OW-1:0] v);
    logic [WW-1:0] e;
    e = WW'(v);
    if (e == '0) begin
      ld_init = TICK_WIDTH'(1);
    end else if (e > TickMaxW) begin
      ld_init = {TICK_WIDTH{1'b1}};
    end else begin
      ld_init = e[TICK_WIDTH-1:0];
    end
  endfunction

  function automatic tsts_pkg::out_item_t build_out(
    input logic [SW-1:0]         cs,
    input logic [TICK_WIDTH-1:0] sp,
    input logic [TICK_WIDTH-1:0] ep,
    input logic [tsts_pkg::MASK_W-1:0] mask
  );
    tsts_pkg::out_item_t o;
    o.send_enable = mask[cs];
    o.slot_index  = cs;
    o.slot_ticks  = to_out(sp);
    o.epoch_ticks = to_out(ep);
    build_out = o;
  endfunction

  assign n_eff = (slot_count_q == '0) ? CW'(1)
               : (slot_count_q > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : slot_count_q;

  assign in_i.ready = (state_q == S_IDLE) && !pend_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign se_inc  = (se_q == {TICK_WIDTH{1'b1}}) ? se_q : se_q + TICK_WIDTH'(1);
  assign ee_inc  = (ee_q == {TICK_WIDTH{1'b1}}) ? ee_q : ee_q + TICK_WIDTH'(1);
  assign nxt7    = {1'b0, cs_q} + CW'(1);
  assign nxt6    = cs_q + SW'(1);
  assign code7   = {1'b0, in_i.payload.rx_slot};
  assign sum_gap = {1'b0, sp_q} + {1'b0, se_q};
  assign sum_quo = {1'b0, sp_q} + {1'b0, u_quo};
  assign sp_gap  = sum_gap[TICK_WIDTH] ? {TICK_WIDTH{1'b1}} : sum_gap[TICK_WIDTH-1:0];
  assign sp_quo  = sum_quo[TICK_WIDTH] ? {TICK_WIDTH{1'b1}} : sum_quo[TICK_WIDTH-1:0];

  tsts_divmul #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_divmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .a_i    (ua),
    .b_i    (n_eff),
    .done_o (u_done),
    .quo_o  (u_quo),
    .rem_o  (u_rem),
    .prod_o (u_prod)
  );

  always_comb begin
    state_d    = state_q;
    cs_d       = cs_q;
    se_d       = se_q;
    ee_d       = ee_q;
    sp_d       = sp_q;
    ep_d       = ep_q;
    synced_d   = synced_q;
    te_d       = te_q;
    ureq.start = 1'b0;
    ureq.op    = tsts_pkg::OP_DIV;
    ua         = '0;
    fin        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          fin = 1'b1;
          if (!in_i.payload.mode) begin
            if (synced_q) begin
              se_d = se_inc;
              ee_d = ee_inc;
              if (alg_q == tsts_pkg::ALG_GAP) begin
                if (se_inc >= sp_q) begin
                  te_d = 1'b1;
                  se_d = '0;
                  if (nxt7 < n_eff) begin
                    cs_d = nxt7[SW-1:0];
                  end else if (nxt7 == n_eff) begin
                    cs_d = '0;
                  end else begin
                    ureq.start = 1'b1;
                    ua         = TICK_WIDTH'(nxt7);
                    state_d    = S_SLOT;
                    fin        = 1'b0;
                  end
                end
              end else if (alg_q == tsts_pkg::ALG_EPOCH) begin
                if (se_inc >= sp_q) begin
                  se_d = '0;
                  if (({1'b0, nxt6} >= n_eff) || (nxt6 == '0)) begin
                    cs_d = '0;
                    ee_d = '0;
                  end else begin
                    cs_d = nxt6;
                  end
                end
              end
            end
          end else if (alg_q == tsts_pkg::ALG_GAP) begin
            if (code7 < n_eff) begin
              cs_d = in_i.payload.rx_slot;
            end else begin
              ureq.start = 1'b1;
              ua         = TICK_WIDTH'(code7);
              state_d    = S_SLOT;
              fin        = 1'b0;
            end
            if (!te_q) begin
              if (synced_q) begin
                sp_d = (se_q == '0) ? TICK_WIDTH'(1) : se_q;
              end else begin
                synced_d = 1'b1;
              end
              se_d = '0;
            end else begin
              sp_d = sp_gap;
              te_d = 1'b0;
            end
          end else if (alg_q == tsts_pkg::ALG_EPOCH) begin
            if (!synced_q) begin
              synced_d = 1'b1;
              ee_d     = '0;
              se_d     = '0;
            end else if ({1'b0, cs_q} == n_eff - CW'(1)) begin
              cs_d       = '0;
              ep_d       = ee_q;
              se_d       = '0;
              ee_d       = '0;
              ureq.start = 1'b1;
              ua         = ee_q;
              state_d    = S_QSP;
              fin        = 1'b0;
            end else if (cs_q == '0) begin
              ureq.start = 1'b1;
              ua         = ee_q;
              state_d    = S_ADDQ;
              fin        = 1'b0;
            end
          end
        end
      end
      S_SLOT: begin
        if (u_done) begin
          cs_d    = u_rem[SW-1:0];
          state_d = S_IDLE;
          fin     = 1'b1;
        end
      end
      S_QSP: begin
        if (u_done) begin
          sp_d    = (u_quo == '0) ? TICK_WIDTH'(1) : u_quo;
          state_d = S_IDLE;
          fin     = 1'b1;
        end
      end
      S_ADDQ: begin
        if (u_done) begin
          sp_d       = sp_quo;
          ureq.start = 1'b1;
          ureq.op    = tsts_pkg::OP_MUL;
          ua         = sp_quo;
          state_d    = S_MULP;
        end
      end
      S_MULP: begin
        if (u_done) begin
          ep_d    = u_prod;
          state_d = S_IDLE;
          fin     = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i && (cfg_idx_i == tsts_pkg::REG_INIT) && !synced_q) begin
      sp_d = ld_init(cfg_data_i[OW-1:0]);
    end
  end

  always_comb begin
    out_d       = out_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fin) begin
      if (out_free) begin
        out_d       = build_out(cs_d, sp_d, ep_d, mask_q);
        out_valid_d = 1'b1;
      end else begin
        pend_d = 1'b1;
      end
    end else if (pend_q && out_free) begin
      out_d       = build_out(cs_q, sp_q, ep_q, mask_q);
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      alg_q        <= '0;
      slot_count_q <= tsts_pkg::SLOT_COUNT_RST;
      mask_q       <= '0;
      cs_q         <= '0;
      se_q         <= '0;
      ee_q         <= '0;
      sp_q         <= SpReset;
      ep_q         <= '0;
      synced_q     <= 1'b0;
      te_q         <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      se_q        <= se_d;
      ee_q        <= ee_d;
      sp_q        <= sp_d;
      ep_q        <= ep_d;
      synced_q    <= synced_d;
      te_q        <= te_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == tsts_pkg::REG_ALG)) begin
        alg_q <= cfg_data_i[1:0];
      end
      if (cfg_we_i && (cfg_idx_i == tsts_pkg::REG_COUNT)) begin
        slot_count_q <= cfg_data_i[CW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == tsts_pkg::REG_MASK)) begin
        mask_q <= cfg_data_i[tsts_pkg::MASK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q != S_IDLE))
    else $error("Arithmetic unit finished while the sequencer was idle.");

  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("A pending result exists while the output register is empty.");

  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q != '0)
    else $error("Slot period dropped to zero.");

  a_unsynced_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !synced_q |-> ((se_q == '0) && (ee_q == '0)))
    else $error("Tick counters moved before the first time code.");

endmodule
